/* rtl/best_tracker_with_lagged_stop_core_assert.svh */
// Assertion macros for the best tracker core checks.
`ifndef BEST_TRACKER_WITH_LAGGED_STOP_CORE_ASSERT_SVH
`define BEST_TRACKER_WITH_LAGGED_STOP_CORE_ASSERT_SVH

// Checked only out of reset.
`define BTLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define BTLS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/btls_pkg.sv */
// Shared constants, types and functions of the best tracker core.
`timescale 1ns / 1ps

package btls_pkg;

    localparam int VAL_W      = 32;
    localparam int CNT_W      = 32;
    localparam int LAG_W      = 10;
    localparam int RATIO_W    = 16;
    localparam int HIST_DEPTH = 1024;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SUB_W      = VAL_W + 2;
    localparam int DIFF_W     = VAL_W + 1;
    localparam int REL_SHIFT  = RATIO_W + 1;
    localparam int RHS_W      = DIFF_W + RATIO_W;
    localparam int LHS_W      = DIFF_W + REL_SHIFT;

    localparam logic [CNT_W-1:0]   MAX_ITER_RST = CNT_W'(20);
    localparam logic [LAG_W-1:0]   LAG_RST      = LAG_W'(999);
    localparam logic [RATIO_W-1:0] RATIO_RST    = '0;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MINIMIZING = 2'd0,
        REG_MAX_ITER   = 2'd1,
        REG_LAG        = 2'd2,
        REG_RATIO      = 2'd3
    } cfg_reg_t;

    // Item after the input register.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0]        idx;
        logic [CNT_W-1:0]        seen;
        logic                    lag_ok;
        logic                    lag0;
        logic                    limit;
        logic                    use_rel;
    } item_t;

    // Item after the best update.
    typedef struct packed {
        logic                    nb;
        logic signed [VAL_W-1:0] best;
        logic signed [VAL_W-1:0] lagged;
        logic [CNT_W-1:0]        pos;
        logic [CNT_W-1:0]        seen;
        logic                    limit;
        logic                    use_rel;
    } track_t;

    // Item after the magnitude stage.
    typedef struct packed {
        logic                    nb;
        logic signed [VAL_W-1:0] best;
        logic [CNT_W-1:0]        pos;
        logic [CNT_W-1:0]        seen;
        logic                    limit;
        logic                    use_rel;
        logic [DIFF_W-1:0]       diff;
        logic [DIFF_W-1:0]       sum;
    } meas_t;

    typedef struct packed {
        logic                    improved;
        logic signed [VAL_W-1:0] best_value;
        logic [CNT_W-1:0]        best_index;
        logic [CNT_W-1:0]        item_count;
        logic                    keep_going;
    } res_t;

    function automatic logic signed [VAL_W-1:0] extreme(input logic minimizing);
        return minimizing ? VAL_MAX : VAL_MIN;
    endfunction

    function automatic logic better(input logic minimizing,
                                    input logic signed [VAL_W-1:0] a,
                                    input logic signed [VAL_W-1:0] b);
        return minimizing ? (a < b) : (a > b);
    endfunction

endpackage

/* rtl/btls_ring.sv */
// History ring: one write port, one registered read port.
`timescale 1ns / 1ps

module btls_ring
    import btls_pkg::*;
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [HIST_AW-1:0]      wr_addr,
    input  logic signed [VAL_W-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [HIST_AW-1:0]      rd_addr,
    output logic signed [VAL_W-1:0] rd_data
);

    logic signed [VAL_W-1:0] ring_mem [HIST_DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;

    // read sees contents before this edge's write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/btls_update.sv */
// Best and lagged-best state with their per-item update.
`timescale 1ns / 1ps

module btls_update
    import btls_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  item_t                   item,
    input  logic signed [VAL_W-1:0] rd_data,
    input  logic                    minimizing,
    input  logic                    reinit,
    input  logic                    reinit_mode,
    output track_t                  trk
);

    logic signed [VAL_W-1:0] best_reg;
    logic signed [VAL_W-1:0] best_next;
    logic signed [VAL_W-1:0] lagged_reg;
    logic signed [VAL_W-1:0] lagged_next;
    logic [CNT_W-1:0]        pos_reg;
    logic [CNT_W-1:0]        pos_next;
    logic signed [VAL_W-1:0] old_v;
    logic                    nb;
    logic                    lag_upd;
    track_t                  trk_reg;
    track_t                  trk_next;

    always_comb
    begin
        // lag of zero reads the item itself
        old_v       = item.lag0 ? item.value : rd_data;
        nb          = better(minimizing, item.value, best_reg);
        best_next   = nb ? item.value : best_reg;
        pos_next    = nb ? item.idx : pos_reg;
        lag_upd     = item.lag_ok && better(minimizing, old_v, lagged_reg);
        lagged_next = lag_upd ? old_v : lagged_reg;

        trk_next.nb      = nb;
        trk_next.best    = best_next;
        trk_next.lagged  = lagged_next;
        trk_next.pos     = pos_next;
        trk_next.seen    = item.seen;
        trk_next.limit   = item.limit;
        trk_next.use_rel = item.use_rel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg   <= VAL_MAX;
            lagged_reg <= VAL_MAX;
            pos_reg    <= '0;
        end
        else if (reinit)
        begin
            best_reg   <= extreme(reinit_mode);
            lagged_reg <= extreme(reinit_mode);
        end
        else if (load)
        begin
            best_reg   <= best_next;
            lagged_reg <= lagged_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            trk_reg <= trk_next;
        end
    end

    assign trk = trk_reg;

endmodule

/* rtl/btls_reltest.sv */
// Relative closeness test: magnitudes, then product and compare.
`timescale 1ns / 1ps

module btls_reltest
    import btls_pkg::*;
(
    input  logic               clk,
    input  logic               load_meas,
    input  logic               load_res,
    input  logic [RATIO_W-1:0] ratio,
    input  track_t             trk,
    output res_t               res
);

    logic signed [SUB_W-1:0]  b_ext;
    logic signed [SUB_W-1:0]  l_ext;
    logic signed [SUB_W-1:0]  d;
    logic signed [SUB_W-1:0]  d_abs;
    logic signed [SUB_W-1:0]  b_abs;
    logic signed [SUB_W-1:0]  l_abs;
    logic [SUB_W-1:0]         mag_sum;
    meas_t                    meas_reg;
    meas_t                    meas_next;
    logic [RHS_W-1:0]         rhs;
    logic [LHS_W-1:0]         lhs;
    logic                     close;
    res_t                     res_reg;
    res_t                     res_next;

    always_comb
    begin
        b_ext   = SUB_W'(trk.best);
        l_ext   = SUB_W'(trk.lagged);
        d       = b_ext - l_ext;
        d_abs   = d[SUB_W-1] ? -d : d;
        b_abs   = b_ext[SUB_W-1] ? -b_ext : b_ext;
        l_abs   = l_ext[SUB_W-1] ? -l_ext : l_ext;
        mag_sum = SUB_W'(b_abs) + SUB_W'(l_abs);

        meas_next.nb      = trk.nb;
        meas_next.best    = trk.best;
        meas_next.pos     = trk.pos;
        meas_next.seen    = trk.seen;
        meas_next.limit   = trk.limit;
        meas_next.use_rel = trk.use_rel;
        meas_next.diff    = d_abs[DIFF_W-1:0];
        meas_next.sum     = mag_sum[DIFF_W-1:0];
    end

    always_comb
    begin
        // 2^17*|b-l| < ratio*(|b|+|l|), exact
        rhs   = RHS_W'(meas_reg.sum) * RHS_W'(ratio);
        lhs   = {meas_reg.diff, {REL_SHIFT{1'b0}}};
        close = lhs < LHS_W'(rhs);

        res_next.improved   = meas_reg.nb;
        res_next.best_value = meas_reg.best;
        res_next.best_index = meas_reg.pos;
        res_next.item_count = meas_reg.seen;
        res_next.keep_going = !meas_reg.limit && !(meas_reg.use_rel && close);
    end

    always_ff @(posedge clk)
    begin
        if (load_meas)
        begin
            meas_reg <= meas_next;
        end
        if (load_res)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/best_tracker_with_lagged_stop_core.sv */
// Top level of the running-best tracker with lagged relative stop.
`timescale 1ns / 1ps

// One objective value is taken per transfer and one result comes back for it.
// The core takes a new value every cycle while in_stall is low; a result is presented
// once the input/ring-read register has been loaded at its input transfer edge and
// the best update, the magnitude stage and the multiply-compare result stage have
// been loaded in turn. Stages run as an elastic pipeline, so input transfers continue
// while a result is held, until the stages fill and in_stall is raised.
// The 1024-entry history ring is read one slot per item through its
// registered read port. Configuration writes belong to idle periods only;
// a write of the mode register resets both bests.

module best_tracker_with_lagged_stop_core
    import btls_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [VAL_W-1:0] utility,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    improved,
    output logic signed [VAL_W-1:0] best_value,
    output logic [CNT_W-1:0]        best_index,
    output logic [CNT_W-1:0]        item_count,
    output logic                    keep_going
);

    logic                    minimizing_reg;
    logic [CNT_W-1:0]        max_iter_reg;
    logic [LAG_W-1:0]        lag_reg;
    logic [RATIO_W-1:0]      ratio_reg;
    logic                    reinit;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        idx;
    logic [CNT_W-1:0]        tail_idx;

    logic                    s1_valid_reg;
    logic                    s2_valid_reg;
    logic                    s3_valid_reg;
    logic                    out_valid_reg;
    logic                    rdy_out;
    logic                    rdy3;
    logic                    rdy2;
    logic                    rdy1;
    logic                    accept;
    logic                    load2;
    logic                    load3;
    logic                    load_out;

    item_t                   s1_reg;
    item_t                   s1_next;
    logic signed [VAL_W-1:0] rd_data;
    track_t                  trk;
    res_t                    res;

    // configuration
    assign reinit = cfg_write && (cfg_reg_t'(cfg_index) == REG_MINIMIZING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minimizing_reg <= 1'b1;
            max_iter_reg   <= MAX_ITER_RST;
            lag_reg        <= LAG_RST;
            ratio_reg      <= RATIO_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MINIMIZING: minimizing_reg <= cfg_data[0];
                REG_MAX_ITER:   max_iter_reg   <= cfg_data[CNT_W-1:0];
                REG_LAG:        lag_reg        <= cfg_data[LAG_W-1:0];
                REG_RATIO:      ratio_reg      <= cfg_data[RATIO_W-1:0];
                default:        ;
            endcase
        end
    end

    // pipeline flow
    assign rdy_out  = !out_valid_reg || !out_stall;
    assign rdy3     = !s3_valid_reg || rdy_out;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign accept   = in_valid && rdy1;
    assign load2    = s1_valid_reg && rdy2;
    assign load3    = s2_valid_reg && rdy3;
    assign load_out = s3_valid_reg && rdy_out;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // index and stop flags of the incoming item; count saturates
    always_comb
    begin
        count_next = (&count_reg) ? count_reg : count_reg + CNT_W'(1);
        idx        = count_next - CNT_W'(1);
        tail_idx   = idx - CNT_W'(lag_reg);

        s1_next.value   = utility;
        s1_next.idx     = idx;
        s1_next.seen    = count_next;
        s1_next.lag_ok  = count_next > CNT_W'(lag_reg);
        s1_next.lag0    = (lag_reg == '0);
        s1_next.limit   = count_next >= max_iter_reg;
        s1_next.use_rel = !s1_next.limit && (ratio_reg != '0) && s1_next.lag_ok;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    btls_ring u_ring (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (idx[HIST_AW-1:0]),
        .wr_data (utility),
        .rd_en   (accept),
        .rd_addr (tail_idx[HIST_AW-1:0]),
        .rd_data (rd_data)
    );

    btls_update u_update (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load2),
        .item        (s1_reg),
        .rd_data     (rd_data),
        .minimizing  (minimizing_reg),
        .reinit      (reinit),
        .reinit_mode (cfg_data[0]),
        .trk         (trk)
    );

    btls_reltest u_reltest (
        .clk       (clk),
        .load_meas (load3),
        .load_res  (load_out),
        .ratio     (ratio_reg),
        .trk       (trk),
        .res       (res)
    );

    assign out_valid  = out_valid_reg;
    assign improved   = res.improved;
    assign best_value = res.best_value;
    assign best_index = res.best_index;
    assign item_count = res.item_count;
    assign keep_going = res.keep_going;

endmodule

/* rtl/btls_checker.sv */
// Port-level checks of the best tracker core, bound to the top level.
`timescale 1ns / 1ps
`include "best_tracker_with_lagged_stop_core_assert.svh"

module btls_checker
    import btls_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic                    improved,
    input logic signed [VAL_W-1:0] best_value,
    input logic [CNT_W-1:0]        best_index,
    input logic [CNT_W-1:0]        item_count
);

    logic [VAL_W+2*CNT_W-1:0] outs;
    logic [CNT_W-1:0]         last_idx;

    assign outs     = {best_value, best_index, item_count};
    assign last_idx = item_count - CNT_W'(1);

    `BTLS_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(outs), "held result moved")
    `BTLS_ASSERT(a_index_bound, out_valid |-> best_index < item_count, "best index too high")
    `BTLS_ASSERT(a_gain_pos, out_valid && improved |-> best_index == last_idx, "stale best index")
    `BTLS_ASSERT_RST(a_reset_idle, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind best_tracker_with_lagged_stop_core btls_checker u_btls_checker (.*);
